[sv/bitmap_page_frame_allocator_defines.svh]
// Assertion macros used by the checker file bpfa_sva.sv.
// Each assumes a clock named clk and an active-low reset named rst_n in scope.
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_DEFINES_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_DEFINES_SVH

// Same-cycle implication.
`define BPFA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bpfa: same-cycle check failed");

// Next-cycle implication.
`define BPFA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bpfa: next-cycle check failed");

`endif

[sv/bpfa_pkg.sv]
`timescale 1ns / 1ps
package bpfa_pkg;

  localparam int BPFA_MAX_FRAMES       = 4096;
  localparam int BPFA_PAGE_OFFSET_BITS = 12;

  localparam int ADDR_W      = 40;
  localparam int BASE_W      = 28;
  localparam int COUNT_W     = 13;
  localparam int WORD_BITS   = 64;
  localparam int WORD_BIT_W  = 6;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 3;

  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(4096);

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } bpfa_op_t;

  typedef enum logic [1:0] {
    ST_ALLOC = 2'd0,
    ST_FREED = 2'd1,
    ST_FULL  = 2'd2,
    ST_BAD   = 2'd3
  } bpfa_status_t;

  typedef enum logic {
    REG_BASE_FRAME  = 1'b0,
    REG_FRAME_COUNT = 1'b1
  } bpfa_reg_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ASTART,
    S_CHK,
    S_PICK,
    S_AWR,
    S_FCHK,
    S_FRD,
    S_FWR,
    S_RESP
  } bpfa_state_t;

  typedef struct packed {
    logic [BASE_W-1:0]  base_frame;
    logic [COUNT_W-1:0] frame_count;
  } bpfa_cfg_t;

  typedef struct packed {
    logic clear_wr;
    logic capture;
    logic start_scan;
    logic scan_next;
    logic scan_hit;
    logic pick;
    logic alloc_wr;
    logic set_full;
    logic free_chk;
    logic free_wr;
    logic load_out;
  } bpfa_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic hint_ok;
    logic hit;
    logic more;
    logic bad;
    logic out_free;
  } bpfa_stat_t;

endpackage

[sv/bpfa_regs.sv]
`timescale 1ns / 1ps
module bpfa_regs import bpfa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output bpfa_cfg_t             cfg
);

  logic [BASE_W-1:0]  base_frame_r;
  logic [COUNT_W-1:0] frame_count_r;
  bpfa_reg_t          reg_sel;
  logic               wr_en;

  assign reg_sel = bpfa_reg_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_frame_r  <= '0;
      frame_count_r <= COUNT_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_BASE_FRAME:  base_frame_r  <= pwdata[BASE_W-1:0];
        REG_FRAME_COUNT: frame_count_r <= pwdata[COUNT_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_BASE_FRAME:  prdata = APB_DATA_W'(base_frame_r);
      REG_FRAME_COUNT: prdata = APB_DATA_W'(frame_count_r);
    endcase
  end

  assign cfg.base_frame  = base_frame_r;
  assign cfg.frame_count = frame_count_r;

endmodule

[sv/bpfa_ctrl.sv]
`timescale 1ns / 1ps
module bpfa_ctrl import bpfa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_opcode,
  output logic       in_ready,
  input  bpfa_stat_t stat,
  output bpfa_cmd_t  cmd
);

  bpfa_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (stat.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = (bpfa_op_t'(in_opcode) == OP_FREE) ? S_FCHK : S_ASTART;
        end
      end
      S_ASTART: begin
        cmd.start_scan = 1'b1;
        if (stat.hint_ok) begin
          state_nxt = S_CHK;
        end else begin
          cmd.set_full = 1'b1;
          state_nxt    = S_RESP;
        end
      end
      S_CHK: begin
        priority if (stat.hit) begin
          cmd.scan_hit = 1'b1;
          state_nxt    = S_PICK;
        end else if (stat.more) begin
          cmd.scan_next = 1'b1;
        end else begin
          cmd.set_full = 1'b1;
          state_nxt    = S_RESP;
        end
      end
      S_PICK: begin
        cmd.pick  = 1'b1;
        state_nxt = S_AWR;
      end
      S_AWR: begin
        cmd.alloc_wr = 1'b1;
        state_nxt    = S_RESP;
      end
      S_FCHK: begin
        cmd.free_chk = 1'b1;
        state_nxt    = S_FRD;
      end
      S_FRD: begin
        // map word for the freed frame is being read in this cycle
        state_nxt = stat.bad ? S_RESP : S_FWR;
      end
      S_FWR: begin
        cmd.free_wr = 1'b1;
        state_nxt   = S_RESP;
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

[sv/bpfa_dp.sv]
`timescale 1ns / 1ps
module bpfa_dp import bpfa_pkg::*; #(
  parameter int MAX_FRAMES       = BPFA_MAX_FRAMES,
  parameter int PAGE_OFFSET_BITS = BPFA_PAGE_OFFSET_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bpfa_cmd_t           cmd,
  output bpfa_stat_t          stat,
  input  bpfa_cfg_t           cfg,
  input  logic [ADDR_W-1:0]   in_page_address,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [ADDR_W-1:0]   out_granted_address,
  output logic [1:0]          out_status
);

  localparam int CNT_W     = $clog2(MAX_FRAMES + 1);
  localparam int IDX_W     = (CNT_W > WORD_BIT_W + 1) ? CNT_W : WORD_BIT_W + 1;
  localparam int WP_W      = IDX_W - WORD_BIT_W;
  localparam int MAP_WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int LIM_W     = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam int FR_W      = ADDR_W - PAGE_OFFSET_BITS;
  localparam int DIF_W     = ((FR_W > BASE_W) ? FR_W : BASE_W) + 1;
  localparam int SUM_W     = ((IDX_W > BASE_W) ? IDX_W : BASE_W) + 1;

  function automatic logic [WORD_BIT_W-1:0] ffs_word(input logic [WORD_BITS-1:0] v);
    logic [WORD_BIT_W-1:0] r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) r = WORD_BIT_W'(i);
    end
    return r;
  endfunction

  // free map, one bit per frame, 1 = free
  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [WORD_BITS-1:0] rdata_r;
  logic [AW-1:0]        raddr, waddr;
  logic [WORD_BITS-1:0] wdata;
  logic                 we;

  logic [LIM_W-1:0]      cnt_ext;
  logic [CNT_W-1:0]      n_eff;
  logic [IDX_W-1:0]      n_x, hint_x;
  logic [WP_W-1:0]       n_word, hint_word;
  logic [WORD_BIT_W-1:0] n_bit, hint_bit;

  logic [CNT_W-1:0]      hint_r, hint_nxt;
  logic [WP_W-1:0]       word_r, word_nxt, word_inc;
  logic [WP_W:0]         next_cnt, words_used;

  logic [WORD_BITS-1:0]  lo_mask, hi_mask, masked;
  logic [WORD_BITS-1:0]  orig_r, hit_r;
  logic [WORD_BIT_W-1:0] bit_r;
  logic [IDX_W-1:0]      frame_idx;
  logic [IDX_W:0]        frame_inc;
  logic [SUM_W-1:0]      frame_sum;
  logic [ADDR_W-1:0]     frame_ext, granted;

  logic [ADDR_W-1:0]     addr_r;
  logic [FR_W-1:0]       free_frame;
  logic [DIF_W-1:0]      diff;
  logic                  bad;
  logic                  bad_r;
  logic [IDX_W-1:0]      rel_r;
  logic [WP_W-1:0]       rel_word;
  logic [WORD_BIT_W-1:0] rel_bit;

  bpfa_status_t          resp_status_r;
  logic [ADDR_W-1:0]     resp_addr_r;
  logic                  out_valid_r;
  bpfa_status_t          out_status_r;
  logic [ADDR_W-1:0]     out_addr_r;

  // effective frame count
  assign cnt_ext = LIM_W'(cfg.frame_count);
  assign n_eff   = (cnt_ext > LIM_W'(MAX_FRAMES)) ? CNT_W'(MAX_FRAMES) : cnt_ext[CNT_W-1:0];
  assign n_x       = IDX_W'(n_eff);
  assign n_word    = n_x[IDX_W-1:WORD_BIT_W];
  assign n_bit     = n_x[WORD_BIT_W-1:0];
  assign hint_x    = IDX_W'(hint_r);
  assign hint_word = hint_x[IDX_W-1:WORD_BIT_W];
  assign hint_bit  = hint_x[WORD_BIT_W-1:0];

  assign word_inc   = word_r + WP_W'(1);
  assign next_cnt   = {1'b0, word_r} + (WP_W + 1)'(1);
  assign words_used = {1'b0, n_word} + (WP_W + 1)'(n_bit != '0);

  // keep only frames at or above the hint and below the count
  always_comb begin
    lo_mask = '1;
    if (word_r == hint_word) begin
      lo_mask = ~((WORD_BITS'(1) << hint_bit) - WORD_BITS'(1));
    end
    priority if (word_r < n_word) begin
      hi_mask = '1;
    end else if (word_r == n_word) begin
      hi_mask = (WORD_BITS'(1) << n_bit) - WORD_BITS'(1);
    end else begin
      hi_mask = '0;
    end
  end
  assign masked = rdata_r & lo_mask & hi_mask;

  assign frame_idx = {word_r, bit_r};
  assign frame_inc = {1'b0, frame_idx} + (IDX_W + 1)'(1);
  assign frame_sum = SUM_W'(cfg.base_frame) + SUM_W'(frame_idx);
  assign frame_ext = ADDR_W'(frame_sum);
  assign granted   = frame_ext << PAGE_OFFSET_BITS;

  // free address check
  assign free_frame = addr_r[ADDR_W-1:PAGE_OFFSET_BITS];
  assign diff       = DIF_W'(free_frame) - DIF_W'(cfg.base_frame);
  assign bad        = (|addr_r[PAGE_OFFSET_BITS-1:0]) || diff[DIF_W-1] ||
                      (diff[DIF_W-2:0] >= (DIF_W - 1)'(n_eff));
  assign rel_word   = rel_r[IDX_W-1:WORD_BIT_W];
  assign rel_bit    = rel_r[WORD_BIT_W-1:0];

  always_comb begin
    priority if (cmd.start_scan) begin
      raddr = hint_word[AW-1:0];
    end else if (cmd.scan_next) begin
      raddr = word_inc[AW-1:0];
    end else begin
      raddr = rel_word[AW-1:0];
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = word_r[AW-1:0];
    wdata = '1;
    priority if (cmd.clear_wr) begin
      we = 1'b1;
    end else if (cmd.alloc_wr) begin
      we    = 1'b1;
      wdata = orig_r & ~(WORD_BITS'(1) << bit_r);
    end else if (cmd.free_wr) begin
      we    = 1'b1;
      waddr = rel_word[AW-1:0];
      wdata = rdata_r | (WORD_BITS'(1) << rel_bit);
    end else begin
      we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_comb begin
    word_nxt = word_r;
    priority if (cmd.clear_wr) begin
      word_nxt = word_inc;
    end else if (cmd.start_scan) begin
      word_nxt = hint_word;
    end else if (cmd.scan_next) begin
      word_nxt = word_inc;
    end else begin
      word_nxt = word_r;
    end
  end

  always_comb begin
    hint_nxt = hint_r;
    priority if (cmd.alloc_wr) begin
      hint_nxt = frame_inc[CNT_W-1:0];
    end else if (cmd.free_wr && (rel_r < hint_x)) begin
      hint_nxt = rel_r[CNT_W-1:0];
    end else begin
      hint_nxt = hint_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r      <= '0;
      hint_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      word_r <= word_nxt;
      hint_r <= hint_nxt;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      addr_r <= in_page_address;
    end
    if (cmd.scan_hit) begin
      orig_r <= rdata_r;
      hit_r  <= masked;
    end
    if (cmd.pick) begin
      bit_r <= ffs_word(hit_r);
    end
    if (cmd.free_chk) begin
      bad_r <= bad;
      rel_r <= diff[IDX_W-1:0];
    end
    priority if (cmd.set_full) begin
      resp_status_r <= ST_FULL;
      resp_addr_r   <= '0;
    end else if (cmd.alloc_wr) begin
      resp_status_r <= ST_ALLOC;
      resp_addr_r   <= granted;
    end else if (cmd.free_chk) begin
      resp_status_r <= bad ? ST_BAD : ST_FREED;
      resp_addr_r   <= '0;
    end else begin
      resp_status_r <= resp_status_r;
    end
    if (cmd.load_out) begin
      out_status_r <= resp_status_r;
      out_addr_r   <= resp_addr_r;
    end
  end

  assign stat.clear_last = (word_r == WP_W'(MAP_WORDS - 1));
  assign stat.hint_ok    = (hint_r < n_eff);
  assign stat.hit        = |masked;
  assign stat.more       = (next_cnt < words_used);
  assign stat.bad        = bad_r;
  assign stat.out_free   = !out_valid_r || out_ready;

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_granted_address = out_addr_r;

endmodule

[sv/bitmap_page_frame_allocator.sv]
`timescale 1ns / 1ps
// Page frame allocator over a one-bit-per-frame free map with a lowest-free hint.
// Request channel (in_valid/in_ready): in_opcode 0 allocates a page, 1 frees
// in_page_address. Result channel (out_valid/out_ready): one result per request,
// out_status 0 allocated, 1 freed, 2 no free frame, 3 bad free address, and
// out_granted_address (zero unless a page was granted).
// APB port: base_frame at 0x0, frame_count at 0x4; write only while idle.
// One request is in work at a time. Allocate: scans one 64-bit map word per
// cycle from the hint. A scan that finds no free frame answers with status 2,
// as does an allocate with the hint at or past the count, which does not scan.
// Free: read-modify-write of one map word; a rejected address answers without
// the write. The map memory has a single read and a single write port.
// Reset: base_frame 0, frame_count 4096, hint 0; then a clearing pass writes
// every map word free, one word per cycle, during which in_ready stays low.
// A stalled result waits in the output register; the next request is still
// taken and worked on, and its result waits until the output register frees.
module bitmap_page_frame_allocator import bpfa_pkg::*; #(
  parameter int MAX_FRAMES       = BPFA_MAX_FRAMES,
  parameter int PAGE_OFFSET_BITS = BPFA_PAGE_OFFSET_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_opcode,
  input  logic [ADDR_W-1:0]     in_page_address,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ADDR_W-1:0]     out_granted_address,
  output logic [1:0]            out_status,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  bpfa_cfg_t  cfg;
  bpfa_cmd_t  cmd;
  bpfa_stat_t stat;

  bpfa_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bpfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_ready  (in_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bpfa_dp #(
    .MAX_FRAMES       (MAX_FRAMES),
    .PAGE_OFFSET_BITS (PAGE_OFFSET_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .cfg                 (cfg),
    .in_page_address     (in_page_address),
    .out_ready           (out_ready),
    .out_valid           (out_valid),
    .out_granted_address (out_granted_address),
    .out_status          (out_status)
  );

endmodule

[sv/bpfa_sva.sv]
`timescale 1ns / 1ps
`include "bitmap_page_frame_allocator_defines.svh"
module bpfa_sva import bpfa_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [ADDR_W-1:0] out_granted_address,
  input logic [1:0]        out_status
);

  // a stalled result holds
  `BPFA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_granted_address) && $stable(out_status))

  // only a grant carries an address
  `BPFA_ASSERT_NOW(a_addr_zero, out_valid && (out_status != ST_ALLOC), out_granted_address == '0)

  // granted pages are at least 256-byte aligned while PAGE_OFFSET_BITS is 8 or more
  `BPFA_ASSERT_NOW(a_addr_align, out_valid, out_granted_address[7:0] == 8'h00)

  // map clearing pass blocks requests right after reset
  `BPFA_ASSERT_NOW(a_clear_block, $past(!rst_n), !in_ready)

endmodule

bind bitmap_page_frame_allocator bpfa_sva u_bpfa_sva (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_ready            (in_ready),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_granted_address (out_granted_address),
  .out_status          (out_status)
);
